// File: rtl/core/iabo_pkg.sv
// Types and constants shared by the immediate ALU and bit operation unit.
`default_nettype none

package iabo_pkg;

  localparam logic [3:0] OP_ORI      = 4'd0;
  localparam logic [3:0] OP_ANDI     = 4'd1;
  localparam logic [3:0] OP_EORI     = 4'd2;
  localparam logic [3:0] OP_ADDI     = 4'd3;
  localparam logic [3:0] OP_SUBI     = 4'd4;
  localparam logic [3:0] OP_CMPI     = 4'd5;
  localparam logic [3:0] OP_BTST     = 4'd6;
  localparam logic [3:0] OP_BCLR     = 4'd7;
  localparam logic [3:0] OP_BSET     = 4'd8;
  localparam logic [3:0] OP_ORI_CCR  = 4'd9;
  localparam logic [3:0] OP_ANDI_CCR = 4'd10;
  localparam logic [3:0] OP_ORI_SR   = 4'd11;
  localparam logic [3:0] OP_ANDI_SR  = 4'd12;

  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_WORD   = 2'd1;
  localparam logic [1:0] SZ_LONG   = 2'd2;
  localparam logic [1:0] SZ_UNUSED = 2'd3;

  localparam logic [15:0] SR_IMPL  = 16'hA71F;
  localparam logic [15:0] SR_RESET = 16'h2700;
  localparam int unsigned SR_S_BIT = 13;

  localparam int unsigned CC_X = 4;
  localparam int unsigned CC_N = 3;
  localparam int unsigned CC_Z = 2;
  localparam int unsigned CC_V = 1;
  localparam int unsigned CC_C = 0;

  typedef struct packed {
    logic [3:0]  operation;
    logic [1:0]  operand_size;
    logic [31:0] destination_value;
    logic [31:0] source_value;
  } iabo_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_back;
    logic [15:0] status_after;
    logic        privilege_fault;
  } iabo_out_t;

endpackage

`default_nettype wire

// File: rtl/core/iabo_exec.sv
// Combinational execute logic for one immediate-group instruction.
`default_nettype none

module iabo_exec (
  input  iabo_pkg::iabo_in_t  req,
  input  logic [15:0]         status_in,
  output iabo_pkg::iabo_out_t resp
);

  always_comb begin
    logic [31:0] m;
    logic [31:0] h;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] res;
    logic [31:0] bm;
    logic [31:0] bmask;
    logic [4:0]  bitn;
    logic [4:0]  cc;
    logic [15:0] sr;
    logic        wb;
    logic        fault;
    logic        n_f;
    logic        z_f;
    logic        sa;
    logic        sb;
    logic        sr_bit;
    logic        borrow;

    unique case (req.operand_size)
      iabo_pkg::SZ_BYTE: begin
        m = 32'h0000_00FF;
        h = 32'h0000_0080;
      end
      iabo_pkg::SZ_WORD: begin
        m = 32'h0000_FFFF;
        h = 32'h0000_8000;
      end
      default: begin
        m = 32'hFFFF_FFFF;
        h = 32'h8000_0000;
      end
    endcase

    a   = req.destination_value & m;
    b   = req.source_value & m;
    sr  = status_in;
    cc  = status_in[4:0];
    res = req.destination_value;
    wb  = 1'b0;
    fault = 1'b0;

    unique case (req.operation) inside
      iabo_pkg::OP_ORI:  r = a | b;
      iabo_pkg::OP_ANDI: r = a & b;
      iabo_pkg::OP_EORI: r = a ^ b;
      iabo_pkg::OP_ADDI: r = (a + b) & m;
      iabo_pkg::OP_SUBI, iabo_pkg::OP_CMPI: r = (a - b) & m;
      default: r = a;
    endcase

    n_f    = |(r & h);
    z_f    = (r == 32'd0);
    sa     = |(a & h);
    sb     = |(b & h);
    sr_bit = |(r & h);
    borrow = (b > a);

    if (req.operand_size == iabo_pkg::SZ_BYTE) begin
      bm   = 32'h0000_00FF;
      bitn = {2'b00, req.source_value[2:0]};
    end else begin
      bm   = 32'hFFFF_FFFF;
      bitn = req.source_value[4:0];
    end
    bmask = 32'd1 << bitn;

    unique case (req.operation) inside
      iabo_pkg::OP_ORI, iabo_pkg::OP_ANDI, iabo_pkg::OP_EORI: begin
        wb  = 1'b1;
        res = (req.destination_value & ~m) | r;
        cc  = {status_in[iabo_pkg::CC_X], n_f, z_f, 2'b00};
      end
      iabo_pkg::OP_ADDI: begin
        wb  = 1'b1;
        res = (req.destination_value & ~m) | r;
        cc  = {(r < a), n_f, z_f, (sa == sb) && (sr_bit != sa), (r < a)};
      end
      iabo_pkg::OP_SUBI: begin
        wb  = 1'b1;
        res = (req.destination_value & ~m) | r;
        cc  = {borrow, n_f, z_f, (sa != sb) && (sr_bit != sa), borrow};
      end
      iabo_pkg::OP_CMPI: begin
        cc = {status_in[iabo_pkg::CC_X], n_f, z_f, (sa != sb) && (sr_bit != sa), borrow};
      end
      iabo_pkg::OP_BTST: begin
        cc[iabo_pkg::CC_Z] = ((req.destination_value & bm & bmask) == 32'd0);
      end
      iabo_pkg::OP_BCLR: begin
        cc[iabo_pkg::CC_Z] = ((req.destination_value & bm & bmask) == 32'd0);
        wb  = 1'b1;
        res = (req.destination_value & ~bm) | (req.destination_value & bm & ~bmask);
      end
      iabo_pkg::OP_BSET: begin
        cc[iabo_pkg::CC_Z] = ((req.destination_value & bm & bmask) == 32'd0);
        wb  = 1'b1;
        res = (req.destination_value & ~bm) | ((req.destination_value & bm) | bmask);
      end
      iabo_pkg::OP_ORI_CCR: begin
        cc = status_in[4:0] | req.source_value[4:0];
      end
      iabo_pkg::OP_ANDI_CCR: begin
        cc = status_in[4:0] & req.source_value[4:0];
      end
      default: begin
      end
    endcase

    unique case (req.operation) inside
      iabo_pkg::OP_ORI_SR, iabo_pkg::OP_ANDI_SR: begin
        if (!status_in[iabo_pkg::SR_S_BIT]) begin
          fault = 1'b1;
        end else if (req.operation == iabo_pkg::OP_ORI_SR) begin
          sr = status_in | req.source_value[15:0];
        end else begin
          sr = status_in & req.source_value[15:0];
        end
      end
      iabo_pkg::OP_ORI, iabo_pkg::OP_ANDI, iabo_pkg::OP_EORI, iabo_pkg::OP_ADDI,
      iabo_pkg::OP_SUBI, iabo_pkg::OP_CMPI, iabo_pkg::OP_BTST, iabo_pkg::OP_BCLR,
      iabo_pkg::OP_BSET, iabo_pkg::OP_ORI_CCR, iabo_pkg::OP_ANDI_CCR: begin
        sr = {status_in[15:8], 3'b000, cc};
      end
      default: begin
        sr = status_in;
      end
    endcase

    resp.result_value    = res;
    resp.write_back      = wb;
    resp.status_after    = sr & iabo_pkg::SR_IMPL;
    resp.privilege_fault = fault;
  end

endmodule

`default_nettype wire

// File: rtl/core/immediate_alu_and_bit_ops_unit.sv
// Top level of the immediate ALU and bit operation unit with its status word.
//
// The in_ channel carries one instruction request per handshake: operation,
// operand size, destination contents and immediate or bit number. The out_
// channel returns the merged destination, a write-back flag, the status
// word after the instruction and a privilege-violation flag.
// A request is captured in an input register; the execute logic evaluates it
// against the status register, and once the output register is free the
// response moves into it while the status register takes the new value. One
// request per cycle is sustained while the receiver keeps out_ready high; the
// status register is updated as each response is registered, so back-to-back
// requests see each other's flags.
// When the receiver stalls, the output register holds its response, the
// input register holds one more request, and in_ready then drops.
// Synchronous reset empties both registers and sets the status word to
// supervisor state with interrupt mask seven.
`default_nettype none

module immediate_alu_and_bit_ops_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iabo_pkg::iabo_in_t  in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output iabo_pkg::iabo_out_t out_resp
);

  logic                in_valid_r;
  iabo_pkg::iabo_in_t  in_req_r;
  logic                out_valid_r;
  iabo_pkg::iabo_out_t out_resp_r;
  logic [15:0]         status_r;
  iabo_pkg::iabo_out_t exec_resp;
  logic                advance;

  iabo_exec u_exec (
    .req       (in_req_r),
    .status_in (status_r),
    .resp      (exec_resp)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= iabo_pkg::SR_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        status_r    <= exec_resp.status_after;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= in_req;
    end
    if (advance) begin
      out_resp_r <= exec_resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

`ifndef ASSERT_OFF
  a_status_impl: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r & ~iabo_pkg::SR_IMPL) == 16'd0)
    else $error("status register holds unimplemented bits");

  a_fault_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_resp_r.privilege_fault |-> !out_resp_r.write_back)
    else $error("privilege fault with write-back");

  a_fault_keeps_sr: assert property (@(posedge clk) disable iff (!rst_n)
    advance && exec_resp.privilege_fault |=> status_r == $past(status_r))
    else $error("privilege fault changed the status word");

  a_status_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && (out_resp_r.status_after == status_r))
    else $error("response status differs from status register");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("request side stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

// File: tb/sv/immediate_alu_and_bit_ops_unit_tb.sv
// Self-checking testbench for the immediate ALU and bit operation unit.
`timescale 1ns / 100ps

module immediate_alu_and_bit_ops_unit_tb;

  class iabo_response_checker;
    logic [15:0] status;
    iabo_pkg::iabo_out_t pending_responses[$];
    int unsigned errors;

    function new();
      status = iabo_pkg::SR_RESET;
      errors = 0;
    endfunction

    function iabo_pkg::iabo_out_t execute_instruction(iabo_pkg::iabo_in_t req);
      logic [31:0] d, s, m, h, a, b, r, bm, bmask, v;
      logic [15:0] sr;
      logic [4:0] cc;
      logic [4:0] bit_no;
      logic n, z, carry, ovf;
      iabo_pkg::iabo_out_t o;
      d = req.destination_value;
      s = req.source_value;
      case (req.operand_size)
        iabo_pkg::SZ_BYTE: begin
          m = 32'h0000_00ff;
          h = 32'h0000_0080;
        end
        iabo_pkg::SZ_WORD: begin
          m = 32'h0000_ffff;
          h = 32'h0000_8000;
        end
        default: begin
          m = 32'hffff_ffff;
          h = 32'h8000_0000;
        end
      endcase
      a = d & m;
      b = s & m;
      sr = status;
      cc = sr[4:0];
      o.result_value = d;
      o.write_back = 1'b0;
      o.privilege_fault = 1'b0;
      bm = (req.operand_size == iabo_pkg::SZ_BYTE) ? 32'h0000_00ff : 32'hffff_ffff;
      bit_no = (req.operand_size == iabo_pkg::SZ_BYTE) ? {2'b00, s[2:0]} : s[4:0];
      bmask = 32'd1 << bit_no;
      v = d & bm;
      case (req.operation) inside
        iabo_pkg::OP_ORI, iabo_pkg::OP_ANDI, iabo_pkg::OP_EORI, iabo_pkg::OP_ADDI,
        iabo_pkg::OP_SUBI, iabo_pkg::OP_CMPI: begin
          case (req.operation)
            iabo_pkg::OP_ORI: r = a | b;
            iabo_pkg::OP_ANDI: r = a & b;
            iabo_pkg::OP_EORI: r = a ^ b;
            iabo_pkg::OP_ADDI: r = (a + b) & m;
            default: r = (a - b) & m;
          endcase
          n = |(r & h);
          z = (r == 32'd0);
          if (req.operation != iabo_pkg::OP_CMPI) begin
            o.write_back = 1'b1;
            o.result_value = (d & ~m) | r;
          end
          if (req.operation == iabo_pkg::OP_ADDI) begin
            carry = (r < a);
            ovf = ((a & h) == (b & h)) && ((r & h) != (a & h));
            cc = {carry, n, z, ovf, carry};
          end else if (req.operation == iabo_pkg::OP_SUBI ||
                       req.operation == iabo_pkg::OP_CMPI) begin
            carry = (b > a);
            ovf = ((a & h) != (b & h)) && ((r & h) != (a & h));
            cc = {(req.operation == iabo_pkg::OP_SUBI) ? carry : cc[iabo_pkg::CC_X],
                  n, z, ovf, carry};
          end else begin
            cc = {cc[iabo_pkg::CC_X], n, z, 2'b00};
          end
          sr[7:0] = {3'b000, cc};
        end
        iabo_pkg::OP_BTST, iabo_pkg::OP_BCLR, iabo_pkg::OP_BSET: begin
          cc[iabo_pkg::CC_Z] = ((v & bmask) == 32'd0);
          if (req.operation == iabo_pkg::OP_BCLR) begin
            o.result_value = (d & ~bm) | (v & ~bmask);
            o.write_back = 1'b1;
          end else if (req.operation == iabo_pkg::OP_BSET) begin
            o.result_value = (d & ~bm) | (v | bmask);
            o.write_back = 1'b1;
          end
          sr[7:0] = {3'b000, cc};
        end
        iabo_pkg::OP_ORI_CCR: sr[7:0] = {3'b000, cc | s[4:0]};
        iabo_pkg::OP_ANDI_CCR: sr[7:0] = {3'b000, cc & s[4:0]};
        iabo_pkg::OP_ORI_SR, iabo_pkg::OP_ANDI_SR: begin
          if (!sr[iabo_pkg::SR_S_BIT]) begin
            o.privilege_fault = 1'b1;
          end else if (req.operation == iabo_pkg::OP_ORI_SR) begin
            sr = sr | s[15:0];
          end else begin
            sr = sr & s[15:0];
          end
        end
        default: ;
      endcase
      status = sr & iabo_pkg::SR_IMPL;
      o.status_after = status;
      return o;
    endfunction

    function void note_request(iabo_pkg::iabo_in_t req);
      pending_responses.push_back(execute_instruction(req));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_response(iabo_pkg::iabo_out_t resp);
      iabo_pkg::iabo_out_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch("response with no request outstanding", resp.result_value, 32'd0);
      end else begin
        want = pending_responses.pop_front();
        if (resp.result_value !== want.result_value)
          report_mismatch("result_value", resp.result_value, want.result_value);
        if (resp.write_back !== want.write_back)
          report_mismatch("write_back", 32'(resp.write_back), 32'(want.write_back));
        if (resp.status_after !== want.status_after)
          report_mismatch("status_after", 32'(resp.status_after), 32'(want.status_after));
        if (resp.privilege_fault !== want.privilege_fault)
          report_mismatch("privilege_fault", 32'(resp.privilege_fault),
                          32'(want.privilege_fault));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  iabo_pkg::iabo_in_t in_req;
  logic out_valid;
  logic out_ready;
  iabo_pkg::iabo_out_t out_resp;

  iabo_response_checker checker_h = new();
  int unsigned send_gap_limit = 8;
  int unsigned recv_stall_limit = 8;

  immediate_alu_and_bit_ops_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_resp (out_resp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) checker_h.check_response(out_resp);
      if (in_valid && in_ready) checker_h.note_request(in_req);
    end
  end

  function iabo_pkg::iabo_in_t make_request(logic [3:0] op, logic [1:0] size,
                                            logic [31:0] d, logic [31:0] s);
    iabo_pkg::iabo_in_t req;
    req.operation = op;
    req.operand_size = size;
    req.destination_value = d;
    req.source_value = s;
    return req;
  endfunction

  function logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function iabo_pkg::iabo_in_t random_request(bit keep_supervisor);
    iabo_pkg::iabo_in_t req;
    req.operation = 4'($urandom_range(0, 15));
    req.operand_size = 2'($urandom_range(0, 3));
    req.destination_value = pick_operand();
    req.source_value = ($urandom_range(0, 7) == 0) ? req.destination_value : pick_operand();
    if (keep_supervisor && req.operation == iabo_pkg::OP_ANDI_SR)
      req.source_value[iabo_pkg::SR_S_BIT] = 1'b1;
    return req;
  endfunction

  task send_request(iabo_pkg::iabo_in_t req);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_limit);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned taken;
    int unsigned stall;
    bit held;
    taken = 0;
    held = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) recv_stall_limit = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (!held && taken >= 300) begin
        held = 1;
        stall = 60;
      end else begin
        stall = $urandom_range(0, recv_stall_limit);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    iabo_pkg::iabo_in_t directed[$];
    int unsigned i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    directed = '{
      make_request(iabo_pkg::OP_ORI, iabo_pkg::SZ_BYTE, 32'h1234_5600, 32'h0000_0000),
      make_request(iabo_pkg::OP_ORI, iabo_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_8000),
      make_request(iabo_pkg::OP_ANDI, iabo_pkg::SZ_LONG, 32'hffff_ffff, 32'hffff_ffff),
      make_request(iabo_pkg::OP_EORI, iabo_pkg::SZ_LONG, 32'ha5a5_a5a5, 32'ha5a5_a5a5),
      make_request(iabo_pkg::OP_ADDI, iabo_pkg::SZ_BYTE, 32'hffff_ff7f, 32'h0000_0001),
      make_request(iabo_pkg::OP_ADDI, iabo_pkg::SZ_WORD, 32'h0000_ffff, 32'h0000_0001),
      make_request(iabo_pkg::OP_ADDI, iabo_pkg::SZ_LONG, 32'h7fff_ffff, 32'h7fff_ffff),
      make_request(iabo_pkg::OP_ADDI, iabo_pkg::SZ_UNUSED, 32'hffff_ffff, 32'h0000_0001),
      make_request(iabo_pkg::OP_SUBI, iabo_pkg::SZ_BYTE, 32'h0000_0000, 32'h0000_0001),
      make_request(iabo_pkg::OP_SUBI, iabo_pkg::SZ_LONG, 32'h8000_0000, 32'h0000_0001),
      make_request(iabo_pkg::OP_CMPI, iabo_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_0001),
      make_request(iabo_pkg::OP_CMPI, iabo_pkg::SZ_LONG, 32'hdead_beef, 32'hdead_beef),
      make_request(iabo_pkg::OP_BTST, iabo_pkg::SZ_BYTE, 32'h0000_0000, 32'hffff_ff0f),
      make_request(iabo_pkg::OP_BTST, iabo_pkg::SZ_LONG, 32'h8000_0000, 32'h0000_001f),
      make_request(iabo_pkg::OP_BCLR, iabo_pkg::SZ_BYTE, 32'hffff_ffff, 32'h0000_0003),
      make_request(iabo_pkg::OP_BSET, iabo_pkg::SZ_LONG, 32'h0000_0000, 32'h0000_003f),
      make_request(iabo_pkg::OP_BSET, iabo_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_0010),
      make_request(iabo_pkg::OP_BCLR, iabo_pkg::SZ_UNUSED, 32'hffff_ffff, 32'h0000_0020),
      make_request(iabo_pkg::OP_ORI_CCR, iabo_pkg::SZ_BYTE, 32'h0000_0000, 32'hffff_ff1f),
      make_request(iabo_pkg::OP_ANDI_CCR, iabo_pkg::SZ_BYTE, 32'h0000_0000, 32'h0000_0000),
      make_request(iabo_pkg::OP_ORI_SR, iabo_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_ffff),
      make_request(iabo_pkg::OP_ANDI_SR, iabo_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_a71f),
      make_request(4'd13, iabo_pkg::SZ_BYTE, 32'h0123_4567, 32'hffff_ffff),
      make_request(4'd14, iabo_pkg::SZ_WORD, 32'h89ab_cdef, 32'h0000_0000),
      make_request(4'd15, iabo_pkg::SZ_LONG, 32'hffff_ffff, 32'h0000_2000)
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[k]) send_request(directed[k]);
    for (i = 0; i < 1200; i++) begin
      if (i % 64 == 0) send_gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 8;
      send_request(random_request(1'b1));
    end
    // Leaving supervisor state cannot be undone, so user-state traffic runs last.
    send_request(make_request(iabo_pkg::OP_ANDI_SR, iabo_pkg::SZ_WORD, 32'h0000_0000,
                              32'h0000_0000));
    send_request(make_request(iabo_pkg::OP_ORI_SR, iabo_pkg::SZ_WORD, 32'hffff_ffff,
                              32'h0000_ffff));
    send_request(make_request(iabo_pkg::OP_ANDI_SR, iabo_pkg::SZ_WORD, 32'h0000_0000,
                              32'hffff_ffff));
    for (i = 0; i < 100; i++) send_request(random_request(1'b0));
    in_valid <= 1'b0;
    while (checker_h.pending_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (checker_h.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
